/* src/amr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the AMR fine-grid fill block.
// No dependencies; every other file in src imports this package.
package amr_pkg;

    localparam int LVL_W    = 3;   // refinement level
    localparam int POS_W    = 7;   // column / row fields of an item
    localparam int ID_W     = 14;  // cell number
    localparam int BASE_W   = 8;   // base_size register
    localparam int CRD_W    = 10;  // fine-grid coordinate, wide enough for the largest grid
    localparam int CALC_W   = 16;  // footprint and limit arithmetic
    localparam int SIDE_W   = 7;   // sweep offset inside one footprint
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int CMDQ_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE = 1'b1;

    localparam logic [LVL_W-1:0]  MAX_LEVEL_RST = 3'd6;
    localparam logic [BASE_W-1:0] BASE_SIZE_RST = 8'd2;

    localparam logic KIND_FILL = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [LVL_W-1:0]  cell_level;
        logic [POS_W-1:0]  cell_col;
        logic [POS_W-1:0]  cell_row;
        logic [ID_W-1:0]   cell_id;
        logic [POS_W-1:0]  read_x;
        logic [POS_W-1:0]  read_y;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0] value;
        logic            in_range;
    } t_out_item;

    // Classified work for the back end
    typedef struct packed {
        logic              kind;
        logic [CRD_W-1:0]  x;        // read position or footprint origin
        logic [CRD_W-1:0]  y;
        logic [LVL_W-1:0]  side_log; // footprint side is 2^side_log
        logic [ID_W-1:0]   id;
        logic              in_range;
    } t_cmd;

    typedef struct packed {
        logic clearing;
        logic busy;
    } t_back_stat;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_READ
    } t_back_state;

endpackage

/* src/amr_front.sv */
`timescale 1ns / 1ps
// Front end: configuration registers and item classification.
// Depends on amr_pkg.
module amr_front #(
    parameter int GRID_SIDE = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [amr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [amr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_valid,
    input  amr_pkg::t_in_item             i_item,
    output logic                          o_keep,
    output amr_pkg::t_cmd                 o_cmd
);
    import amr_pkg::*;

    logic [LVL_W-1:0]  r_max_level;
    logic [BASE_W-1:0] r_base_size;

    logic [CALC_W-1:0] fine_side;
    logic [CALC_W-1:0] lim;
    logic [LVL_W-1:0]  side_log;
    logic [CALC_W-1:0] side;
    logic [CALC_W-1:0] x0;
    logic [CALC_W-1:0] y0;
    logic              lvl_ok;
    logic              fits;
    logic              rd_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_level <= MAX_LEVEL_RST;
            r_base_size <= BASE_SIZE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_LEVEL: r_max_level <= i_cfg_data[LVL_W-1:0];
                CFG_BASE_SIZE: r_base_size <= i_cfg_data[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        fine_side = CALC_W'(r_base_size) << r_max_level;
        lim       = (fine_side < CALC_W'(GRID_SIDE)) ? fine_side : CALC_W'(GRID_SIDE);
        lvl_ok    = (i_item.cell_level <= r_max_level);
        side_log  = r_max_level - i_item.cell_level;
        side      = CALC_W'(1) << side_log;
        x0        = CALC_W'(i_item.cell_col) << side_log;
        y0        = CALC_W'(i_item.cell_row) << side_log;
        fits      = ((x0 + side) <= lim) && ((y0 + side) <= lim);
        rd_in     = (CALC_W'(i_item.read_x) < lim) && (CALC_W'(i_item.read_y) < lim);

        o_cmd.kind     = i_item.kind;
        o_cmd.side_log = side_log;
        o_cmd.id       = i_item.cell_id;
        o_cmd.in_range = rd_in;
        if (i_item.kind == KIND_READ) begin
            // park out-of-range reads on entry zero so the address stays legal
            o_cmd.x = rd_in ? CRD_W'(i_item.read_x) : '0;
            o_cmd.y = rd_in ? CRD_W'(i_item.read_y) : '0;
        end else begin
            o_cmd.x = x0[CRD_W-1:0];
            o_cmd.y = y0[CRD_W-1:0];
        end

        // drop inserts that are too fine or stick out of the grid
        o_keep = i_valid && ((i_item.kind == KIND_READ) || (lvl_ok && fits));
    end

endmodule

/* src/amr_cmdq.sv */
`timescale 1ns / 1ps
// Short command queue between front and back end.
// Depends on amr_pkg.
module amr_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  amr_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output amr_pkg::t_cmd o_head
);
    import amr_pkg::*;

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    t_cmd             r_slot [CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* src/amr_back.sv */
`timescale 1ns / 1ps
// Back end: fine-grid memory, clearing pass, footprint sweep and read result register.
// Depends on amr_pkg.
module amr_back #(
    parameter int GRID_SIDE = 128
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    input  amr_pkg::t_cmd          i_cmd,
    output logic                   o_cmd_pop,
    output amr_pkg::t_back_stat    o_stat,
    output logic                   o_out_valid,
    output amr_pkg::t_out_item     o_out,
    input  logic                   i_out_pop
);
    import amr_pkg::*;

    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(GRID_SIDE);

    function automatic logic [AW-1:0] addr_of(input logic [CRD_W-1:0] y,
                                              input logic [CRD_W-1:0] x);
        logic [CW-1:0] yc;
        logic [CW-1:0] xc;
        yc = y[CW-1:0];
        xc = x[CW-1:0];
        return AW'(AW'(yc) * AW'(GRID_SIDE)) + AW'(xc);
    endfunction

    logic [ID_W-1:0] r_mem [DEPTH];
    logic [ID_W-1:0] r_rd_data;

    t_back_state      r_state, n_state;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic [CRD_W-1:0] r_x0, n_x0;
    logic [CRD_W-1:0] r_y0, n_y0;
    logic [SIDE_W-1:0] r_mask, n_mask;
    logic [SIDE_W-1:0] r_dx, n_dx;
    logic [SIDE_W-1:0] r_dy, n_dy;
    logic [ID_W-1:0]  r_id, n_id;
    logic             r_rd_inr, n_rd_inr;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [ID_W-1:0]  mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [CRD_W-1:0] fill_x;
    logic [CRD_W-1:0] fill_y;

    // Memory with separate write and read addresses: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x0     <= n_x0;
        r_y0     <= n_y0;
        r_mask   <= n_mask;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_id     <= n_id;
        r_rd_inr <= n_rd_inr;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_x0        = r_x0;
        n_y0        = r_y0;
        n_mask      = r_mask;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_id        = r_id;
        n_rd_inr    = r_rd_inr;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_pop;
        o_cmd_pop   = 1'b0;

        fill_x    = r_x0 + CRD_W'(r_dx);
        fill_y    = r_y0 + CRD_W'(r_dy);
        mem_we    = 1'b0;
        mem_waddr = addr_of(fill_y, fill_x);
        mem_wdata = r_id;
        mem_raddr = addr_of(i_cmd.y, i_cmd.x);

        case (r_state)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.kind == KIND_READ) begin
                        // issue only when the result register is free by next cycle
                        if (!r_out_valid || i_out_pop) begin
                            o_cmd_pop = 1'b1;
                            n_rd_inr  = i_cmd.in_range;
                            n_state   = ST_READ;
                        end
                    end else begin
                        o_cmd_pop = 1'b1;
                        n_x0      = i_cmd.x;
                        n_y0      = i_cmd.y;
                        n_mask    = SIDE_W'((8'd1 << i_cmd.side_log) - 8'd1);
                        n_dx      = '0;
                        n_dy      = '0;
                        n_id      = i_cmd.id;
                        n_state   = ST_FILL;
                    end
                end
            end
            ST_FILL: begin
                mem_we = 1'b1;
                if (r_dx == r_mask) begin
                    n_dx = '0;
                    if (r_dy == r_mask) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_dy = r_dy + 1'b1;
                    end
                end else begin
                    n_dx = r_dx + 1'b1;
                end
            end
            ST_READ: begin
                n_out_valid    = 1'b1;
                n_out.in_range = r_rd_inr;
                n_out.value    = r_rd_inr ? r_rd_data : '0;
                n_state        = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stat.clearing = (r_state == ST_CLEAR);
    assign o_stat.busy     = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

endmodule

/* src/amr_cell_grid_fill.sv */
`timescale 1ns / 1ps
// Top level of the AMR fine-grid fill block: front end, command queue, back end.
// Depends on amr_pkg, amr_front, amr_cmdq and amr_back.
//
// Keeps a GRID_SIDE x GRID_SIDE grid of cell numbers at the finest mesh level.
// An insert item writes its cell number into every fine entry the cell covers;
// a read item returns the number at one fine position, with in_range low and
// value zero when the position lies outside the configured grid. Inserts that
// are finer than max_level or stick out of the grid are dropped at the front.
// After reset the grid is cleared one entry per cycle, and full stays high
// until the clearing pass is done; configuration writes are taken during that
// time. A kept insert holds the back end while it sweeps its footprint, one
// memory write per cycle. A read goes through the registered memory read port
// and then the result register. A four-entry command queue lets new items
// come in while the back end sweeps a footprint or a result waits to be popped.
// Write configuration only while the block is idle.
module amr_cell_grid_fill #(
    parameter int GRID_SIDE = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [amr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [amr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  amr_pkg::t_in_item              i_item,
    output logic                           empty,
    input  logic                           pop,
    output amr_pkg::t_out_item             o_result
);
    import amr_pkg::*;

    logic       front_keep;
    t_cmd       front_cmd;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    t_cmd       q_head;
    t_back_stat back_stat;
    logic       out_valid;
    logic       item_take;

    // Hold off new items during the clearing pass and when the queue is full
    assign full      = q_full || back_stat.clearing;
    assign item_take = push && !full;

    amr_front #(
        .GRID_SIDE (GRID_SIDE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (item_take),
        .i_item     (i_item),
        .o_keep     (front_keep),
        .o_cmd      (front_cmd)
    );

    amr_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_keep),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    amr_back #(
        .GRID_SIDE (GRID_SIDE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_head),
        .o_cmd_pop   (q_pop),
        .o_stat      (back_stat),
        .o_out_valid (out_valid),
        .o_out       (o_result),
        .i_out_pop   (pop)
    );

    // Drive empty from the result register
    assign empty = !out_valid;

    // Out-of-range reads must carry a zero value
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.in_range) |-> (o_result.value == '0))
        else $error("out-of-range result with nonzero value");

    // A read taken by the back end shows up on the result ports after the read state and the result register
    a_read_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop && q_valid && (q_head.kind == KIND_READ)) |-> ##2 !empty)
        else $error("read result missing");

    // The clearing pass keeps the input side closed right after reset
    a_clear_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (full && back_stat.busy))
        else $error("input open during clearing pass");

endmodule

/* test/amr_grid_checker.sv */
`timescale 1ns / 1ps
// Checker for amr_cell_grid_fill: keeps its own fine grid, predicts read results and
// compares them with what the block pops. Depends on amr_pkg only.
module amr_grid_checker #(
    parameter int GRID_SIDE = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [amr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [amr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_push,
    input  logic                           i_full,
    input  amr_pkg::t_in_item              i_item,
    input  logic                           i_empty,
    input  logic                           i_pop,
    input  amr_pkg::t_out_item             i_result,
    output int                             o_fail_count,
    output int                             o_pending
);
    import amr_pkg::*;

    logic [ID_W-1:0]   grid_cells [GRID_SIDE*GRID_SIDE];
    logic [LVL_W-1:0]  cfg_max_level;
    logic [BASE_W-1:0] cfg_base_size;
    t_out_item         expected_reads [$];
    int                fail_count = 0;

    // Usable grid side: configured mesh width clipped to the stored grid.
    function automatic int fine_limit();
        int fine;
        fine = int'(cfg_base_size) << cfg_max_level;
        return (fine < GRID_SIDE) ? fine : GRID_SIDE;
    endfunction

    // Fill a footprint or queue the value a read must return.
    task automatic apply_item(input t_in_item it);
        int        lim;
        int        side;
        int        x0;
        int        y0;
        t_out_item res;
        lim = fine_limit();
        if (it.kind == KIND_FILL) begin
            if (it.cell_level > cfg_max_level) return;
            side = 1 << (int'(cfg_max_level) - int'(it.cell_level));
            x0   = int'(it.cell_col) * side;
            y0   = int'(it.cell_row) * side;
            // drop the whole cell if any part sticks out
            if (x0 + side > lim || y0 + side > lim) return;
            for (int dy = 0; dy < side; dy++)
                for (int dx = 0; dx < side; dx++)
                    grid_cells[(y0 + dy) * GRID_SIDE + x0 + dx] = it.cell_id;
        end else begin
            if (int'(it.read_x) < lim && int'(it.read_y) < lim) begin
                res.value    = grid_cells[int'(it.read_y) * GRID_SIDE + int'(it.read_x)];
                res.in_range = 1'b1;
            end else begin
                res.value    = '0;
                res.in_range = 1'b0;
            end
            expected_reads.push_back(res);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < GRID_SIDE * GRID_SIDE; i++) grid_cells[i] = '0;
            cfg_max_level = MAX_LEVEL_RST;
            cfg_base_size = BASE_SIZE_RST;
            expected_reads.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_LEVEL: cfg_max_level = i_cfg_data[LVL_W-1:0];
                    CFG_BASE_SIZE: cfg_base_size = i_cfg_data[BASE_W-1:0];
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) begin
                if (expected_reads.size() == 0) begin
                    $display("%0t: stray result: expected none, got value %0d in_range %0d",
                             $time, i_result.value, i_result.in_range);
                    fail_count++;
                end else begin
                    want = expected_reads.pop_front();
                    if (i_result.value !== want.value) begin
                        $display("%0t: value mismatch: expected %0d, got %0d",
                                 $time, want.value, i_result.value);
                        fail_count++;
                    end
                    if (i_result.in_range !== want.in_range) begin
                        $display("%0t: in_range mismatch: expected %0d, got %0d",
                                 $time, want.in_range, i_result.in_range);
                        fail_count++;
                    end
                end
            end
            if (i_push && !i_full) apply_item(i_item);
        end
        o_pending    <= expected_reads.size();
        o_fail_count <= fail_count;
    end

endmodule

/* test/amr_cell_grid_fill_tb.sv */
`timescale 1ns / 1ps
// Top of the amr_cell_grid_fill testbench: clock, reset, stimulus and verdict.
// Depends on amr_pkg, the block under test and amr_grid_checker.
module amr_cell_grid_fill_tb;
    import amr_pkg::*;

    localparam int GRID_SIDE       = 128;
    localparam int N_PHASES        = 11;
    localparam int ITEMS_PER_PHASE = 83;
    // Extra wait after the last read result leaves, so the back end can go idle.
    localparam int DRAIN_TAIL      = 12;
    // Slowest run: the clearing pass, the directed fills, ~1000 items each at
    // worst a large footprint fill plus the longest gap on both sides; several times over.
    localparam int LIMIT_CYCLES    = 2_000_000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_MAX_LEVEL;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    t_in_item              in_item = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    t_out_item             result;

    int fails;
    int pending;
    int pop_hold = 0;
    int idle_pct = 30;
    int cycle_count = 0;
    int n_items = 0;
    int n_reads = 0;
    int n_settings = 0;

    amr_cell_grid_fill #(
        .GRID_SIDE (GRID_SIDE)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .push       (push),
        .full       (full),
        .i_item     (in_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (result)
    );

    amr_grid_checker #(
        .GRID_SIDE (GRID_SIDE)
    ) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_push       (push),
        .i_full       (full),
        .i_item       (in_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (result),
        .o_fail_count (fails),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap length: none most of the time, otherwise mostly short, sometimes a long stall.
    function automatic int idle_len(input int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
        return $urandom_range(8, 50);
    endfunction

    // Stimulus-side view of the grid width, used only to aim items inside it.
    function automatic int grid_limit(input int ml, input int bs);
        int fine;
        fine = bs << ml;
        return (fine < GRID_SIDE) ? fine : GRID_SIDE;
    endfunction

    // Insert item; the unused read fields carry random bits.
    function automatic t_in_item mk_fill(input int lvl, input int col, input int row,
                                         input int id);
        t_in_item it;
        it.kind       = KIND_FILL;
        it.cell_level = LVL_W'(lvl);
        it.cell_col   = POS_W'(col);
        it.cell_row   = POS_W'(row);
        it.cell_id    = ID_W'(id);
        it.read_x     = POS_W'($urandom_range(0, 127));
        it.read_y     = POS_W'($urandom_range(0, 127));
        return it;
    endfunction

    // Read item; the unused cell fields carry random bits.
    function automatic t_in_item mk_read(input int x, input int y);
        t_in_item it;
        it.kind       = KIND_READ;
        it.cell_level = LVL_W'($urandom_range(0, 7));
        it.cell_col   = POS_W'($urandom_range(0, 127));
        it.cell_row   = POS_W'($urandom_range(0, 127));
        it.cell_id    = ID_W'($urandom_range(0, 16383));
        it.read_x     = POS_W'(x);
        it.read_y     = POS_W'(y);
        return it;
    endfunction

    // Mostly well-formed items aimed inside the current grid, mostly fine cells;
    // the rest is raw noise, cells too fine for max_level, or footprints that stick out.
    function automatic t_in_item random_item(input int ml, input int lim);
        t_in_item it;
        int       p;
        int       d;
        int       ncell;
        it.kind       = 1'($urandom_range(0, 1));
        it.cell_level = LVL_W'($urandom_range(0, 7));
        it.cell_col   = POS_W'($urandom_range(0, 127));
        it.cell_row   = POS_W'($urandom_range(0, 127));
        it.cell_id    = ID_W'($urandom_range(0, 16383));
        it.read_x     = POS_W'($urandom_range(0, 127));
        it.read_y     = POS_W'($urandom_range(0, 127));
        if ($urandom_range(0, 99) < 10) return it;
        if ($urandom_range(0, 99) < 55) begin
            it.kind = KIND_FILL;
            p = $urandom_range(0, 99);
            d = (p < 70) ? 0 : (p < 90) ? 1 : (p < 97) ? $urandom_range(2, 3) : 4;
            if (d > ml) d = ml;
            it.cell_level = LVL_W'(ml - d);
            ncell = lim >> d;
            if (ncell > 0) begin
                it.cell_col = POS_W'($urandom_range(0, ncell - 1));
                it.cell_row = POS_W'($urandom_range(0, ncell - 1));
            end
            if ($urandom_range(0, 99) < 8) begin
                if (ml < 7) it.cell_level = LVL_W'($urandom_range(ml + 1, 7));
                else if (ncell < 128) it.cell_col = POS_W'(ncell);
            end
        end else begin
            it.kind = KIND_READ;
            if (lim > 0 && $urandom_range(0, 99) < 85) begin
                it.read_x = POS_W'($urandom_range(0, lim - 1));
                it.read_y = POS_W'($urandom_range(0, lim - 1));
            end
        end
        return it;
    endfunction

    // Grid settings per phase: one-entry grid, max level with the smallest and
    // largest base, zero base, odd widths that leave part of the stored grid unused.
    function automatic void pick_setting(input int p, output int ml, output int bs);
        case (p)
            1:       begin ml = 0; bs = 1;   end
            2:       begin ml = 7; bs = 1;   end
            3:       begin ml = 7; bs = 255; end
            4:       begin ml = 3; bs = 5;   end
            5:       begin ml = 0; bs = 0;   end
            6:       begin ml = 2; bs = 100; end
            7:       begin ml = 5; bs = 3;   end
            8:       begin ml = 1; bs = 128; end
            9:       begin ml = 4; bs = 7;   end
            10:      begin ml = 7; bs = 200; end
            default: begin ml = 6; bs = 2;   end
        endcase
    endfunction

    // Offer one item after an optional gap; hold it until the block takes it.
    task automatic push_item(input t_in_item it);
        int gap;
        gap = idle_len(idle_pct);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (full);
        n_items++;
        if (it.kind == KIND_READ) n_reads++;
    endtask

    // Hold off the sender until every read result has been popped, then let the
    // back end settle. Reads queue behind fills, so an empty result queue after a
    // read means every earlier footprint has been written.
    task automatic drain();
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    // Write both registers on back-to-back cycles; the max_level data carries
    // random upper bits, which the block must ignore.
    task automatic set_config(input int ml, input int bs);
        logic [CFG_DATA_W-1:0] data;
        data            = CFG_DATA_W'($urandom);
        data[LVL_W-1:0] = LVL_W'(ml);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MAX_LEVEL;
        cfg_data <= data;
        @(posedge clk);
        cfg_idx  <= CFG_BASE_SIZE;
        cfg_data <= CFG_DATA_W'(bs);
        @(posedge clk);
        cfg_we   <= 1'b0;
        n_settings++;
    endtask

    // Result side: pop freely, with random stalls whose density follows idle_pct.
    always @(posedge clk) begin
        if (!rst_n) begin
            pop      <= 1'b0;
            pop_hold <= 0;
        end else if (pop_hold > 0) begin
            pop      <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else begin
            pop      <= 1'b1;
            pop_hold <= idle_len(idle_pct);
        end
    end

    // Timeout guard.
    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int ml;
        int bs;
        int lim;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset setting (max_level 6, base 2: 128 across).
        // The block clears its grid first; the first push waits out full.
        ml = int'(MAX_LEVEL_RST);
        bs = int'(BASE_SIZE_RST);
        push_item(mk_read(0, 0));                  // cleared grid reads zero
        push_item(mk_read(127, 127));
        push_item(mk_fill(0, 0, 0, 16383));        // coarsest cell: 64x64 block
        push_item(mk_read(0, 0));
        push_item(mk_read(63, 63));
        push_item(mk_read(64, 0));                 // just outside that block
        push_item(mk_fill(6, 127, 127, 1));        // finest cell in the far corner
        push_item(mk_read(127, 127));
        push_item(mk_fill(7, 5, 5, 77));           // finer than max_level: dropped
        push_item(mk_read(5, 5));
        push_item(mk_read(10, 10));
        push_item(mk_fill(1, 2, 0, 100));          // 32x32 at x 64..95
        push_item(mk_read(95, 31));
        push_item(mk_read(96, 0));
        push_item(mk_fill(1, 4, 0, 200));          // footprint past the right edge
        push_item(mk_read(127, 0));
        push_item(mk_fill(1, 3, 3, 300));          // overwrite the corner cell
        push_item(mk_read(127, 127));
        push_item(mk_fill(6, 0, 0, 0));            // write a zero over one entry
        push_item(mk_read(0, 0));
        push_item(mk_read(1, 0));
        push_item(mk_fill(5, 127, 0, 42));         // column past the grid: dropped
        push_item(mk_read(126, 1));
        drain();

        // Random phases, one grid setting each. Stored entries stay in place
        // across a setting change, so later phases read earlier footprints.
        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0) begin
                pick_setting(p, ml, bs);
                set_config(ml, bs);
            end
            // every third phase runs with no idling on either side
            idle_pct <= (p % 3 == 1) ? 0 : 30;
            lim = grid_limit(ml, bs);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (p % 4 == 2 && k == ITEMS_PER_PHASE / 2) drain();
                push_item(random_item(ml, lim));
            end
            // close the phase with a read so the drain covers all fills
            push_item(mk_read($urandom_range(0, 127), $urandom_range(0, 127)));
            drain();
        end

        $display("Covered %0d items (%0d reads) over %0d register settings,",
                 n_items, n_reads, n_settings + 1);
        $display("from a one-entry grid to the full 128x128 grid, zero base, overhangs");
        if (fails == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
